@@ sv/satbs_pkg.sv @@
// ----------------------------------------------------------------------------
// satbs_pkg
// Types and constants shared by the satellite batch sender modules.
// ----------------------------------------------------------------------------
package satbs_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0]  COUNT_MAX     = 8'd127;
  localparam logic [6:0]  ID_MAX        = 7'd127;
  localparam logic [15:0] WAIT_MAX      = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd240;

  localparam int PADDR_W     = 3;
  localparam int QUEUE_DEPTH = 4;

  // Register index as decoded from paddr[2].
  localparam logic REG_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_COUNTER = 2'd2
  } kind_t;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_CLEAR = 1'b1
  } act_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CTR,
    BS_HDR,
    BS_ENT,
    BS_CLEAR
  } bstate_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  entry_index;
    logic [7:0]  sat_id;
    logic [15:0] azimuth;
    logic [7:0]  elevation;
    logic [7:0]  carrier_noise;
    logic        list_ready;
    logic [7:0]  list_count;
    logic [7:0]  done_count;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  count_out;
    logic [7:0]  group_code;
    logic [4:0]  slot;
    logic [6:0]  id_out;
    logic [15:0] azimuth_out;
    logic [7:0]  elevation_out;
    logic [7:0]  noise_out;
    logic [7:0]  counter_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  id;
    logic [15:0] az;
    logic [7:0]  el;
    logic [7:0]  cn;
  } sat_entry_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    sat_entry_t data;
  } store_wr_t;

  // One command per tick that produces words: an optional counter write,
  // followed by either a frame or the final counter clear.
  typedef struct packed {
    logic       ctr_en;
    logic [7:0] ctr_val;
    act_t       act;
    logic [7:0] hdr_count;
    logic [7:0] hdr_group;
    logic [7:0] base;
    logic [5:0] n_entries;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

@@ sv/satellite_batch_sender.sv @@
// ----------------------------------------------------------------------------
// satellite_batch_sender
// Splits a stored satellite list into frames and sends them paced by a
// transmit-done counter.
// ----------------------------------------------------------------------------
// Usage: load words (operation 0) fill the satellite store while no transfer
// runs; tick words (operation 1) start a transfer when a fresh list is
// offered and otherwise pace it through done_count or the timeout register.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The timeout register sits at byte address 0 of the APB port.
// Path: the first word of a tick passes the command queue, the command
// fetch in the back end's idle state and the header state into the output
// register. The back end then sends one word per cycle within a command
// while out_stall is low: a frame takes a command fetch, an optional counter
// write, the header and its entries. The back end's single output path
// sets this rate.
// Reset clears all control state and sets the timeout to 240; the store
// contents stay undefined until loaded. When the receiver stalls, the output
// word holds, the back end waits, up to four commands collect in the queue
// and then in_stall rises. Load words are also held off while any queued or
// running command is still being sent.
// ----------------------------------------------------------------------------
module satellite_batch_sender
  import satbs_pkg::*;
#(
  parameter int MAX_SATS      = 128,
  parameter int FRAME_ENTRIES = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0]  timeout_r, timeout_nxt;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  cmd_t         q_cmd;
  cmd_t         q_head;
  store_wr_t    store_wr;
  back_status_t back_sts;

  assign pready = 1'b1;

  always_comb begin
    timeout_nxt = timeout_r;
    if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT)) begin
      timeout_nxt = pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {16'd0, timeout_r};
    end else begin
      prdata = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  satbs_front #(
    .MAX_SATS      (MAX_SATS),
    .FRAME_ENTRIES (FRAME_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_data       (in_data),
    .in_stall      (in_stall),
    .timeout_ticks (timeout_r),
    .q_full        (q_full),
    .q_empty       (q_empty),
    .back_sts      (back_sts),
    .q_push        (q_push),
    .q_cmd         (q_cmd),
    .store_wr      (store_wr)
  );

  satbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  satbs_back #(
    .MAX_SATS (MAX_SATS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .store_wr  (store_wr),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .back_sts  (back_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ sv/satbs_front.sv @@
// ----------------------------------------------------------------------------
// satbs_front
// Accepts input words, writes store entries, tracks the transfer state and
// queues one command for every tick that produces output words.
// ----------------------------------------------------------------------------
module satbs_front
  import satbs_pkg::*;
#(
  parameter int MAX_SATS      = 128,
  parameter int FRAME_ENTRIES = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  in_item_t     in_data,
  output logic         in_stall,
  input  logic [15:0]  timeout_ticks,
  input  logic         q_full,
  input  logic         q_empty,
  input  back_status_t back_sts,
  output logic         q_push,
  output cmd_t         q_cmd,
  output store_wr_t    store_wr
);

  // Reciprocal for the frame count; exact for dividends below 512.
  localparam int RECIP = (65536 + FRAME_ENTRIES - 1) / FRAME_ENTRIES;

  logic       sending_r, sending_nxt;
  logic [7:0] frame_total_r, frame_total_nxt;
  logic [7:0] frames_ready_r, frames_ready_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0] stored_r, stored_nxt;
  logic [8:0] next_base_r, next_base_nxt;

  logic        accept;
  logic [8:0]  ceil_num;
  logic [25:0] tot_prod;
  logic [7:0]  tot_q;
  logic [7:0]  tot_new;
  logic [15:0] wait_inc;

  logic [7:0] fr_num;
  logic [7:0] fr_num_p1;
  logic [8:0] fr_base;
  logic [7:0] fr_count;
  logic [7:0] fr_total;
  logic [8:0] fr_lim;
  logic [8:0] fr_avail;
  logic [5:0] fr_n;

  logic advance;

  assign in_stall = q_full ||
                    ((in_data.operation == OP_LOAD) && (!q_empty || back_sts.busy));
  assign accept   = in_valid && !in_stall;

  assign ceil_num = 9'(in_data.list_count) + 9'(FRAME_ENTRIES - 1);
  assign tot_prod = 26'(ceil_num) * 26'(RECIP);
  assign tot_q    = tot_prod[23:16];
  assign tot_new  = (tot_q == 8'd0) ? 8'd1 : tot_q;
  assign wait_inc = (wait_r != WAIT_MAX) ? wait_r + 16'd1 : wait_r;

  // Frame description: a new list starts at frame zero, otherwise the next
  // frame of the running transfer.
  always_comb begin
    if (sending_r) begin
      fr_num   = frames_ready_r;
      fr_base  = next_base_r;
      fr_count = stored_r;
      fr_total = frame_total_r;
    end else begin
      fr_num   = 8'd0;
      fr_base  = 9'd0;
      fr_count = in_data.list_count;
      fr_total = tot_new;
    end
    fr_num_p1 = fr_num + 8'd1;
    fr_lim    = (9'(fr_count) > 9'(MAX_SATS)) ? 9'(MAX_SATS) : 9'(fr_count);
    fr_avail  = (fr_lim > fr_base) ? fr_lim - fr_base : 9'd0;
    fr_n      = (fr_avail > 9'(FRAME_ENTRIES)) ? 6'(FRAME_ENTRIES) : fr_avail[5:0];
  end

  always_comb begin
    sending_nxt      = sending_r;
    frame_total_nxt  = frame_total_r;
    frames_ready_nxt = frames_ready_r;
    seen_nxt         = seen_r;
    wait_nxt         = wait_r;
    stored_nxt       = stored_r;
    next_base_nxt    = next_base_r;
    advance          = 1'b0;
    q_push           = 1'b0;
    store_wr         = '0;

    q_cmd           = '0;
    q_cmd.act       = ACT_FRAME;
    q_cmd.hdr_count = (fr_count > COUNT_MAX) ? COUNT_MAX : fr_count;
    q_cmd.hdr_group = {fr_total[3:0], fr_num_p1[3:0]};
    q_cmd.base      = fr_base[7:0];
    q_cmd.n_entries = fr_n;

    if (accept) begin
      if (in_data.operation == OP_LOAD) begin
        if (!sending_r && (9'(in_data.entry_index) < 9'(MAX_SATS))) begin
          store_wr.en      = 1'b1;
          store_wr.addr    = in_data.entry_index;
          store_wr.data.id = (in_data.sat_id > 8'(ID_MAX)) ? ID_MAX : in_data.sat_id[6:0];
          store_wr.data.az = in_data.azimuth;
          store_wr.data.el = in_data.elevation;
          store_wr.data.cn = in_data.carrier_noise;
        end
      end else if (!sending_r) begin
        if (in_data.list_ready) begin
          stored_nxt       = in_data.list_count;
          frame_total_nxt  = tot_new;
          seen_nxt         = in_data.done_count;
          frames_ready_nxt = 8'd1;
          next_base_nxt    = 9'(FRAME_ENTRIES);
          sending_nxt      = 1'b1;
          q_push           = 1'b1;
        end
      end else begin
        if (in_data.done_count != seen_r) begin
          wait_nxt = 16'd0;
          seen_nxt = in_data.done_count;
          advance  = 1'b1;
        end else if (wait_inc >= timeout_ticks) begin
          // Timeout: push the counter forward ourselves.
          wait_nxt       = 16'd0;
          seen_nxt       = seen_r + 8'd1;
          q_cmd.ctr_en   = 1'b1;
          q_cmd.ctr_val  = seen_r + 8'd1;
          advance        = 1'b1;
        end else begin
          wait_nxt = wait_inc;
        end

        if (advance) begin
          q_push = 1'b1;
          if (frames_ready_r < frame_total_r) begin
            frames_ready_nxt = frames_ready_r + 8'd1;
            next_base_nxt    = next_base_r + 9'(FRAME_ENTRIES);
          end else begin
            q_cmd.act   = ACT_CLEAR;
            sending_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r      <= 1'b0;
      frame_total_r  <= 8'd0;
      frames_ready_r <= 8'd0;
      seen_r         <= 8'd0;
      wait_r         <= 16'd0;
      stored_r       <= 8'd0;
      next_base_r    <= 9'd0;
    end else begin
      sending_r      <= sending_nxt;
      frame_total_r  <= frame_total_nxt;
      frames_ready_r <= frames_ready_nxt;
      seen_r         <= seen_nxt;
      wait_r         <= wait_nxt;
      stored_r       <= stored_nxt;
      next_base_r    <= next_base_nxt;
    end
  end

  a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> (frames_ready_r <= frame_total_r))
    else $error("frame counter ran past the frame total");

endmodule

@@ sv/satbs_queue.sv @@
// ----------------------------------------------------------------------------
// satbs_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module satbs_queue
  import satbs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue read while empty");

endmodule

@@ sv/satbs_back.sv @@
// ----------------------------------------------------------------------------
// satbs_back
// Holds the satellite store and turns queued commands into output words,
// one word per cycle while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
module satbs_back
  import satbs_pkg::*;
#(
  parameter int MAX_SATS = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  store_wr_t    store_wr,
  input  logic         q_empty,
  input  cmd_t         q_head,
  output logic         q_pop,
  output back_status_t back_sts,
  output logic         out_valid,
  input  logic         out_stall,
  output out_item_t    out_data
);

  localparam int AW = (MAX_SATS > 1) ? $clog2(MAX_SATS) : 1;

  sat_entry_t mem [MAX_SATS];

  bstate_t       state_r, state_nxt;
  cmd_t          cmd_r;
  logic [5:0]    idx_r, idx_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_en;
  sat_entry_t    rdata_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic      advance;
  logic      ent_last;
  logic      emit;
  out_item_t res;

  assign advance       = !out_valid_r || !out_stall;
  assign ent_last      = (idx_r == cmd_r.n_entries - 6'd1);
  assign q_pop         = (state_r == BS_IDLE) && !q_empty;
  assign back_sts.busy = (state_r != BS_IDLE);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          if (q_head.ctr_en) begin
            state_nxt = BS_CTR;
          end else if (q_head.act == ACT_FRAME) begin
            state_nxt = BS_HDR;
          end else begin
            state_nxt = BS_CLEAR;
          end
        end
      end
      BS_CTR: begin
        if (advance) begin
          state_nxt = (cmd_r.act == ACT_FRAME) ? BS_HDR : BS_CLEAR;
        end
      end
      BS_HDR: begin
        if (advance) begin
          state_nxt = (cmd_r.n_entries != 6'd0) ? BS_ENT : BS_IDLE;
        end
      end
      BS_ENT: begin
        if (advance && ent_last) begin
          state_nxt = BS_IDLE;
        end
      end
      BS_CLEAR: begin
        if (advance) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // The store read for an entry is issued on the word before it, so the
  // registered read data is ready when the entry word goes out.
  always_comb begin
    emit        = 1'b0;
    res         = '0;
    rd_en       = 1'b0;
    rd_addr_nxt = rd_addr_r;
    idx_nxt     = idx_r;
    case (state_r)
      BS_CTR: begin
        if (advance) begin
          emit              = 1'b1;
          res.kind          = KIND_COUNTER;
          res.counter_value = cmd_r.ctr_val;
        end
      end
      BS_HDR: begin
        if (advance) begin
          emit           = 1'b1;
          res.kind       = KIND_HEADER;
          res.count_out  = cmd_r.hdr_count;
          res.group_code = cmd_r.hdr_group;
          res.last       = (cmd_r.n_entries == 6'd0);
          if (cmd_r.n_entries != 6'd0) begin
            rd_en       = 1'b1;
            rd_addr_nxt = cmd_r.base[AW-1:0];
            idx_nxt     = 6'd0;
          end
        end
      end
      BS_ENT: begin
        if (advance) begin
          emit              = 1'b1;
          res.kind          = KIND_ENTRY;
          res.slot          = 5'(idx_r);
          res.id_out        = rdata_r.id;
          res.azimuth_out   = rdata_r.az;
          res.elevation_out = rdata_r.el;
          res.noise_out     = rdata_r.cn;
          res.last          = ent_last;
          if (!ent_last) begin
            rd_en       = 1'b1;
            rd_addr_nxt = rd_addr_r + AW'(1);
            idx_nxt     = idx_r + 6'd1;
          end
        end
      end
      BS_CLEAR: begin
        if (advance) begin
          emit              = 1'b1;
          res.kind          = KIND_COUNTER;
          res.counter_value = 8'd0;
          res.last          = 1'b1;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (emit) begin
      out_data_r <= res;
    end
    idx_r     <= idx_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr[AW-1:0]] <= store_wr.data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr_nxt];
    end
  end

  a_entry_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_ENT) |-> (idx_r < cmd_r.n_entries))
    else $error("entry index beyond the frame length");

  a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.en |-> (state_r == BS_IDLE))
    else $error("store written while a command is in progress");

endmodule
